>>> hw/rtl/awcf_pkg.sv
package awcf_pkg;

  typedef logic [3:0] cmd_t;
  typedef logic [1:0] size_t;
  typedef logic [3:0] cond_t;

  // commands
  localparam cmd_t CmdMove   = 4'd0;
  localparam cmd_t CmdAdd    = 4'd1;
  localparam cmd_t CmdSub    = 4'd2;
  localparam cmd_t CmdCmp    = 4'd3;
  localparam cmd_t CmdDiv    = 4'd4;
  localparam cmd_t CmdMul    = 4'd5;
  localparam cmd_t CmdClr    = 4'd6;
  localparam cmd_t CmdSet    = 4'd7;
  localparam cmd_t CmdBranch = 4'd8;

  // operand sizes; the spare code behaves as word
  localparam size_t SizeByte = 2'd0;
  localparam size_t SizeHalf = 2'd1;

  // flag bit positions, also the flag_select codes
  localparam int unsigned FlagC = 0;
  localparam int unsigned FlagV = 1;
  localparam int unsigned FlagN = 2;
  localparam int unsigned FlagZ = 3;

  // branch conditions
  localparam cond_t CondNe  = 4'd0;
  localparam cond_t CondEq  = 4'd1;
  localparam cond_t CondLt  = 4'd2;
  localparam cond_t CondGt  = 4'd3;
  localparam cond_t CondGe  = 4'd4;
  localparam cond_t CondLe  = 4'd5;
  localparam cond_t CondHi  = 4'd6;
  localparam cond_t CondLos = 4'd7;
  localparam cond_t CondVs  = 4'd8;
  localparam cond_t CondVc  = 4'd9;
  localparam cond_t CondCc  = 4'd10;
  localparam cond_t CondCs  = 4'd11;
  localparam cond_t CondPl  = 4'd12;
  localparam cond_t CondMi  = 4'd13;
  localparam cond_t CondAl  = 4'd14;

  // finished request as handed from the engine to flags and output stage
  typedef struct packed {
    cmd_t        cmd;
    size_t       size;
    logic [32:0] value;  // flag source value incl. bit 32
    logic [31:0] rem;
    logic        ovf;
    logic        dz;
    logic [1:0]  sel;
    cond_t       cond;
  } done_t;

  function automatic logic sign_at(logic [31:0] x, size_t size);
    logic s;
    case (size)
      SizeByte: s = x[7];
      SizeHalf: s = x[15];
      default:  s = x[31];
    endcase
    return s;
  endfunction

  function automatic logic carry_at(logic [32:0] x, size_t size);
    logic c;
    case (size)
      SizeByte: c = x[8];
      SizeHalf: c = x[16];
      default:  c = x[32];
    endcase
    return c;
  endfunction

  function automatic logic zero_at(logic [31:0] x, size_t size);
    logic z;
    case (size)
      SizeByte: z = (x[7:0] == 8'h00);
      SizeHalf: z = (x[15:0] == 16'h0000);
      default:  z = (x == 32'h0000_0000);
    endcase
    return z;
  endfunction

endpackage

>>> hw/rtl/alu_with_condition_flags_top.sv
// Move, add, sub, cmp, flag set/clear, branch test and divide by zero take one execute
//   pass, multiply and divide 32 one-bit steps through the single shared 33-bit adder;
//   either way the result waits in the done state until the output register has a slot.
// The engine holds one request at a time and takes the next once the last is committed.
// Reset (rst_ni, async, active low) clears the sequencer, the output valid and all flags.
module alu_with_condition_flags_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [3:0]  command_i,
  input  logic [1:0]  size_code_i,
  input  logic [31:0] source_value_i,
  input  logic [31:0] dest_value_i,
  input  logic [1:0]  flag_select_i,
  input  logic [3:0]  branch_condition_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] result_value_o,
  output logic [31:0] remainder_value_o,
  output logic        write_result_o,
  output logic        branch_taken_o,
  output logic        flag_n_o,
  output logic        flag_z_o,
  output logic        flag_v_o,
  output logic        flag_c_o,
  output logic        divide_by_zero_o
);

  awcf_pkg::done_t info;
  logic            done;
  logic            commit;
  logic [3:0]      flags_next;
  logic            taken;
  logic            wr;

  logic            out_valid_q, out_valid_d;
  logic [31:0]     result_q;
  logic [31:0]     rem_q;
  logic            wr_q;
  logic            taken_q;
  logic [3:0]      flags_q;
  logic            dz_q;

  // sequencer and shared adder; holds one request at a time
  awcf_engine u_engine (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .command_i          (command_i),
    .size_code_i        (size_code_i),
    .source_value_i     (source_value_i),
    .dest_value_i       (dest_value_i),
    .flag_select_i      (flag_select_i),
    .branch_condition_i (branch_condition_i),
    .done_o             (done),
    .info_o             (info),
    .commit_i           (commit)
  );

  // condition codes only move when the result is committed to the output stage
  awcf_flags u_flags (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .commit_i (commit),
    .info_i   (info),
    .flags_o  (flags_next),
    .taken_o  (taken)
  );

  // output register frees the engine as soon as it has a slot
  assign commit = done && (!out_valid_q || out_ready_i);

  always_comb begin
    case (info.cmd) inside
      awcf_pkg::CmdMove, awcf_pkg::CmdAdd, awcf_pkg::CmdSub,
      awcf_pkg::CmdMul: wr = 1'b1;
      awcf_pkg::CmdDiv: wr = !info.dz;
      default:          wr = 1'b0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      result_q <= info.value[31:0];
      rem_q    <= info.rem;
      wr_q     <= wr;
      taken_q  <= taken;
      flags_q  <= flags_next;
      dz_q     <= info.dz;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign result_value_o    = result_q;
  assign remainder_value_o = rem_q;
  assign write_result_o    = wr_q;
  assign branch_taken_o    = taken_q;
  assign flag_n_o          = flags_q[awcf_pkg::FlagN];
  assign flag_z_o          = flags_q[awcf_pkg::FlagZ];
  assign flag_v_o          = flags_q[awcf_pkg::FlagV];
  assign flag_c_o          = flags_q[awcf_pkg::FlagC];
  assign divide_by_zero_o  = dz_q;

  a_commit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> (out_valid_o && (result_value_o == $past(info.value[31:0]))))
    else $error("committed result not presented");

  a_dz_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && divide_by_zero_o) |-> (!write_result_o && (result_value_o == 32'd0)))
    else $error("divide by zero produced a write");

endmodule

>>> hw/rtl/awcf_adder.sv
// shared 33-bit add/subtract, sum[33] is carry out (no borrow on subtract)
module awcf_adder (
  input  logic [32:0] a_i,
  input  logic [32:0] b_i,
  input  logic        sub_i,
  output logic [33:0] sum_o
);

  logic [32:0] b_eff;

  assign b_eff = sub_i ? ~b_i : b_i;
  assign sum_o = {1'b0, a_i} + {1'b0, b_eff} + {33'd0, sub_i};

endmodule

>>> hw/rtl/awcf_engine.sv
// sequencer around the shared adder: one pass for simple ops,
// 32 shift-add / restoring steps for multiply and divide
module awcf_engine (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  awcf_pkg::cmd_t        command_i,
  input  awcf_pkg::size_t       size_code_i,
  input  logic [31:0]           source_value_i,
  input  logic [31:0]           dest_value_i,
  input  logic [1:0]            flag_select_i,
  input  awcf_pkg::cond_t       branch_condition_i,
  output logic                  done_o,
  output awcf_pkg::done_t       info_o,
  input  logic                  commit_i
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StExec = 2'd1;
  localparam logic [1:0] StIter = 2'd2;
  localparam logic [1:0] StDone = 2'd3;

  logic [1:0]          state_q, state_d;
  logic [4:0]          cnt_q, cnt_d;
  awcf_pkg::cmd_t      cmd_q, cmd_d;
  awcf_pkg::size_t     size_q, size_d;
  logic [1:0]          sel_q, sel_d;
  awcf_pkg::cond_t     cond_q, cond_d;
  logic [31:0]         opnd_q, opnd_d;
  logic [31:0]         acc_q, acc_d;
  logic [31:0]         shf_q, shf_d;
  logic                ovf_q, ovf_d;
  logic                dz_q, dz_d;

  logic [32:0]         add_a, add_b;
  logic                add_sub;
  logic [33:0]         sum;
  logic                arith;
  logic                vs, ss, ds;

  awcf_adder u_adder (
    .a_i   (add_a),
    .b_i   (add_b),
    .sub_i (add_sub),
    .sum_o (sum)
  );

  assign arith = (cmd_q == awcf_pkg::CmdMove) || (cmd_q == awcf_pkg::CmdAdd) ||
                 (cmd_q == awcf_pkg::CmdSub)  || (cmd_q == awcf_pkg::CmdCmp);
  assign vs = awcf_pkg::sign_at(sum[31:0], size_q);
  assign ss = awcf_pkg::sign_at(opnd_q, size_q);
  assign ds = awcf_pkg::sign_at(shf_q, size_q);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_d   = cmd_q;
    size_d  = size_q;
    sel_d   = sel_q;
    cond_d  = cond_q;
    opnd_d  = opnd_q;
    acc_d   = acc_q;
    shf_d   = shf_q;
    ovf_d   = ovf_q;
    dz_d    = dz_q;
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_d  = command_i;
          size_d = size_code_i;
          sel_d  = flag_select_i;
          cond_d = branch_condition_i;
          opnd_d = source_value_i;
          shf_d  = dest_value_i;
          acc_d  = '0;
          cnt_d  = '0;
          ovf_d  = 1'b0;
          dz_d   = 1'b0;
          if ((command_i == awcf_pkg::CmdMul) ||
              ((command_i == awcf_pkg::CmdDiv) && (source_value_i != '0))) begin
            state_d = StIter;
          end else begin
            state_d = StExec;
          end
        end
      end
      StExec: begin
        case (cmd_q)
          awcf_pkg::CmdAdd: begin
            add_a = {1'b0, opnd_q};
            add_b = {1'b0, shf_q};
          end
          awcf_pkg::CmdSub: begin
            add_a   = {1'b0, shf_q};
            add_b   = {1'b0, opnd_q};
            add_sub = 1'b1;
          end
          awcf_pkg::CmdCmp: begin
            add_a   = {1'b0, opnd_q};
            add_b   = {1'b0, shf_q};
            add_sub = 1'b1;
          end
          default: begin
            add_a = {1'b0, opnd_q};
          end
        endcase
        if (arith) begin
          shf_d = sum[31:0];
          // subtract is cut to 32 bits before the flags see it
          acc_d = {31'd0, (cmd_q == awcf_pkg::CmdSub) ? 1'b0 : sum[32]};
          case (cmd_q)
            awcf_pkg::CmdAdd: ovf_d = (vs != ss) && (ss == ds);
            awcf_pkg::CmdSub: ovf_d = (vs == ss) && (ss != ds);
            awcf_pkg::CmdCmp: ovf_d = (vs == ds) && (ss != ds);
            default:          ovf_d = 1'b0;
          endcase
        end else begin
          shf_d = '0;
          acc_d = '0;
          dz_d  = (cmd_q == awcf_pkg::CmdDiv);
        end
        state_d = StDone;
      end
      StIter: begin
        if (cmd_q == awcf_pkg::CmdDiv) begin
          add_a   = {acc_q, shf_q[31]};
          add_b   = {1'b0, opnd_q};
          add_sub = 1'b1;
          acc_d   = sum[33] ? sum[31:0] : add_a[31:0];
          shf_d   = {shf_q[30:0], sum[33]};
        end else begin
          add_a = {1'b0, acc_q};
          add_b = shf_q[0] ? {1'b0, opnd_q} : 33'd0;
          acc_d = sum[32:1];
          shf_d = {sum[0], shf_q[31:1]};
        end
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (commit_i) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    size_q <= size_d;
    sel_q  <= sel_d;
    cond_q <= cond_d;
    opnd_q <= opnd_d;
    acc_q  <= acc_d;
    shf_q  <= shf_d;
    ovf_q  <= ovf_d;
    dz_q   <= dz_d;
  end

  assign in_ready_o = (state_q == StIdle);
  assign done_o     = (state_q == StDone);

  always_comb begin
    info_o.cmd   = cmd_q;
    info_o.size  = size_q;
    info_o.value = (cmd_q == awcf_pkg::CmdDiv) ? {1'b0, shf_q} : {acc_q[0], shf_q};
    info_o.rem   = (cmd_q == awcf_pkg::CmdDiv) ? acc_q : 32'd0;
    info_o.ovf   = ovf_q;
    info_o.dz    = dz_q;
    info_o.sel   = sel_q;
    info_o.cond  = cond_q;
  end

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("engine ready right after taking a request");

  a_cnt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIter) |-> (cnt_q == 5'd0))
    else $error("step counter not clear outside iteration");

  a_done_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !commit_i) |=> (done_o && $stable(info_o)))
    else $error("finished request lost before commit");

endmodule

>>> hw/rtl/awcf_flags.sv
// N Z V C register, next-flag logic and branch test
module awcf_flags (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            commit_i,
  input  awcf_pkg::done_t info_i,
  output logic [3:0]      flags_o,
  output logic            taken_o
);

  logic [3:0] flags_q, flags_d;
  logic [3:0] calc;
  logic [3:0] next;
  logic       n, z, v, c;

  always_comb begin
    calc                  = '0;
    calc[awcf_pkg::FlagC] = awcf_pkg::carry_at(info_i.value, info_i.size);
    calc[awcf_pkg::FlagV] = info_i.ovf;
    calc[awcf_pkg::FlagN] = awcf_pkg::sign_at(info_i.value[31:0], info_i.size);
    calc[awcf_pkg::FlagZ] = awcf_pkg::zero_at(info_i.value[31:0], info_i.size);
  end

  always_comb begin
    case (info_i.cmd) inside
      awcf_pkg::CmdMove, awcf_pkg::CmdAdd, awcf_pkg::CmdSub,
      awcf_pkg::CmdCmp, awcf_pkg::CmdMul: next = calc;
      awcf_pkg::CmdDiv: next = info_i.dz ? flags_q : calc;
      // flag_select codes match the bit positions
      awcf_pkg::CmdClr: next = flags_q & ~(4'b0001 << info_i.sel);
      awcf_pkg::CmdSet: next = flags_q | (4'b0001 << info_i.sel);
      default:          next = flags_q;
    endcase
  end

  assign n = flags_q[awcf_pkg::FlagN];
  assign z = flags_q[awcf_pkg::FlagZ];
  assign v = flags_q[awcf_pkg::FlagV];
  assign c = flags_q[awcf_pkg::FlagC];

  always_comb begin
    taken_o = 1'b0;
    if (info_i.cmd == awcf_pkg::CmdBranch) begin
      unique case (info_i.cond)
        awcf_pkg::CondNe:  taken_o = !z;
        awcf_pkg::CondEq:  taken_o = z;
        awcf_pkg::CondLt:  taken_o = n | v;
        awcf_pkg::CondGt:  taken_o = n ^ v;
        awcf_pkg::CondGe:  taken_o = !(n | v);
        awcf_pkg::CondLe:  taken_o = !(n ^ v);
        awcf_pkg::CondHi:  taken_o = !(c | z);
        awcf_pkg::CondLos: taken_o = c | z;
        awcf_pkg::CondVs:  taken_o = v;
        awcf_pkg::CondVc:  taken_o = !v;
        awcf_pkg::CondCc:  taken_o = !c;
        awcf_pkg::CondCs:  taken_o = c;
        awcf_pkg::CondPl:  taken_o = !n;
        awcf_pkg::CondMi:  taken_o = n;
        awcf_pkg::CondAl:  taken_o = 1'b1;
        default:           taken_o = 1'b0;
      endcase
    end
  end

  assign flags_d = commit_i ? next : flags_q;
  assign flags_o = next;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else begin
      flags_q <= flags_d;
    end
  end

  a_dz_keeps_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit_i && info_i.dz) |=> (flags_q == $past(flags_q)))
    else $error("flags changed on divide by zero");

endmodule

>>> tb/sv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import awcf_pkg::*;

  // Size and command codes that the package leaves unnamed.
  localparam size_t SizeWord  = 2'd2;
  localparam size_t SizeSpare = 2'd3;   // behaves as word
  localparam cmd_t  CmdUnused = 4'd15;  // top of the no-op range
  localparam cond_t CondNever = 4'd15;  // unused condition, never taken

  localparam int unsigned HoldOffCycles = 400;
  // Longest quiet spell in a correct run is the long hold-off plus one
  // multiply or divide; the watchdog allows about nine times that.
  localparam int unsigned StallLimit    = 4000;
  localparam int unsigned DrainCycles   = 40;   // idle time before the final check
  localparam int unsigned PhaseRequests = 500;

  // Overflow rule applied when the flags are rebuilt from a value.
  typedef enum logic [1:0] {OvfNone, OvfAdd, OvfSub, OvfCmp} ovf_rule_e;

  typedef struct packed {
    cmd_t        command;
    size_t       size;
    logic [31:0] source;
    logic [31:0] dest;
    logic [1:0]  flag_sel;
    cond_t       cond;
  } alu_req_t;

  typedef struct packed {
    logic [31:0] result;
    logic [31:0] remainder;
    logic        write_en;
    logic        taken;
    logic        n;
    logic        z;
    logic        v;
    logic        c;
    logic        dz;
  } alu_rsp_t;

  // Keeps its own copy of the NZVC flags, works out the response of every
  // accepted request and checks the responses in order.
  class alu_flags_model;
    logic [3:0]  flags = '0;
    alu_rsp_t    expected_results[$];
    int unsigned failures = 0;

    function void rebuild_flags(logic [63:0] value, logic [31:0] src, logic [31:0] dst,
                                size_t size, ovf_rule_e rule);
      logic [63:0] mask;
      logic [63:0] sign_bit;
      logic        vs, ss, ds, ovf;
      case (size)
        SizeByte: mask = 64'h0000_0000_0000_00ff;
        SizeHalf: mask = 64'h0000_0000_0000_ffff;
        default:  mask = 64'h0000_0000_ffff_ffff;
      endcase
      sign_bit = (mask + 64'd1) >> 1;
      vs = |(value & sign_bit);
      ss = |({32'b0, src} & sign_bit);
      ds = |({32'b0, dst} & sign_bit);
      case (rule)
        OvfAdd:  ovf = (vs != ss) && (ss == ds);
        OvfSub:  ovf = (vs == ss) && (ss != ds);
        OvfCmp:  ovf = (vs == ds) && (ss != ds);
        default: ovf = 1'b0;
      endcase
      flags[FlagZ] = ((value & mask) == 64'd0);
      flags[FlagN] = vs;
      flags[FlagC] = |(value & (mask + 64'd1));
      flags[FlagV] = ovf;
    endfunction

    function void note_request(alu_req_t r);
      alu_rsp_t    e;
      logic [63:0] wide;
      logic        fn, fz, fv, fc;
      e = '0;
      case (r.command)
        CmdMove: begin
          e.result   = r.source;
          e.write_en = 1'b1;
          rebuild_flags({32'b0, r.source}, r.source, r.source, r.size, OvfNone);
        end
        CmdAdd: begin
          wide       = {32'b0, r.source} + {32'b0, r.dest};
          e.result   = wide[31:0];
          e.write_en = 1'b1;
          rebuild_flags(wide, r.source, r.dest, r.size, OvfAdd);
        end
        CmdSub: begin
          // truncated first, so no carry out at word size
          wide       = {32'b0, r.dest - r.source};
          e.result   = wide[31:0];
          e.write_en = 1'b1;
          rebuild_flags(wide, r.source, r.dest, r.size, OvfSub);
        end
        CmdCmp: begin
          wide     = {32'b0, r.source} - {32'b0, r.dest};
          e.result = wide[31:0];
          rebuild_flags(wide, r.source, r.dest, r.size, OvfCmp);
        end
        CmdDiv: begin
          if (r.source == 32'd0) begin
            e.dz = 1'b1;
          end else begin
            e.result    = r.dest / r.source;
            e.remainder = r.dest % r.source;
            e.write_en  = 1'b1;
            rebuild_flags({32'b0, e.result}, 32'd0, 32'd0, r.size, OvfNone);
          end
        end
        CmdMul: begin
          wide       = {32'b0, r.dest} * {32'b0, r.source};
          e.result   = wide[31:0];
          e.write_en = 1'b1;
          rebuild_flags(wide, 32'd0, 32'd0, r.size, OvfNone);
        end
        CmdClr: flags[r.flag_sel] = 1'b0;
        CmdSet: flags[r.flag_sel] = 1'b1;
        CmdBranch: begin
          fn = flags[FlagN];
          fz = flags[FlagZ];
          fv = flags[FlagV];
          fc = flags[FlagC];
          case (r.cond)
            CondNe:  e.taken = !fz;
            CondEq:  e.taken = fz;
            CondLt:  e.taken = fn | fv;
            CondGt:  e.taken = fn ^ fv;
            CondGe:  e.taken = !(fn | fv);
            CondLe:  e.taken = !(fn ^ fv);
            CondHi:  e.taken = !(fc | fz);
            CondLos: e.taken = fc | fz;
            CondVs:  e.taken = fv;
            CondVc:  e.taken = !fv;
            CondCc:  e.taken = !fc;
            CondCs:  e.taken = fc;
            CondPl:  e.taken = !fn;
            CondMi:  e.taken = fn;
            CondAl:  e.taken = 1'b1;
            default: e.taken = 1'b0;
          endcase
        end
        default: ;
      endcase
      e.n = flags[FlagN];
      e.z = flags[FlagZ];
      e.v = flags[FlagV];
      e.c = flags[FlagC];
      expected_results.push_back(e);
    endfunction

    function void check_result(alu_rsp_t got);
      alu_rsp_t e;
      if (expected_results.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("response with no request outstanding: res %h rem %h", got.result,
                   got.remainder);
        return;
      end
      e = expected_results.pop_front();
      if (got !== e) begin
        failures++;
        if (failures <= 10) begin
          $display("mismatch expected: res %h rem %h wr %b br %b nzvc %b%b%b%b dz %b",
                   e.result, e.remainder, e.write_en, e.taken, e.n, e.z, e.v, e.c, e.dz);
          $display("         actual:   res %h rem %h wr %b br %b nzvc %b%b%b%b dz %b",
                   got.result, got.remainder, got.write_en, got.taken, got.n, got.z,
                   got.v, got.c, got.dz);
        end
      end
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [3:0]  command_i;
  logic [1:0]  size_code_i;
  logic [31:0] source_value_i;
  logic [31:0] dest_value_i;
  logic [1:0]  flag_select_i;
  logic [3:0]  branch_condition_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [31:0] result_value_o;
  logic [31:0] remainder_value_o;
  logic        write_result_o;
  logic        branch_taken_o;
  logic        flag_n_o;
  logic        flag_z_o;
  logic        flag_v_o;
  logic        flag_c_o;
  logic        divide_by_zero_o;

  alu_with_condition_flags_top dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .command_i          (command_i),
    .size_code_i        (size_code_i),
    .source_value_i     (source_value_i),
    .dest_value_i       (dest_value_i),
    .flag_select_i      (flag_select_i),
    .branch_condition_i (branch_condition_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .result_value_o     (result_value_o),
    .remainder_value_o  (remainder_value_o),
    .write_result_o     (write_result_o),
    .branch_taken_o     (branch_taken_o),
    .flag_n_o           (flag_n_o),
    .flag_z_o           (flag_z_o),
    .flag_v_o           (flag_v_o),
    .flag_c_o           (flag_c_o),
    .divide_by_zero_o   (divide_by_zero_o)
  );

  alu_flags_model alu_flags;

  // Idling odds in percent per cycle, set per phase by the stimulus.
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  // Raised by the stimulus to ask for one long receiver hold-off.
  bit          hold_off_req   = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Receiver: random stalls, plus the long hold-off counted here so the
  // sender keeps pushing while the block backs up.
  initial begin : result_receiver
    int unsigned hold_left;
    hold_left = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HoldOffCycles - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Responses are sampled at the edge that accepts them; outputs still hold
  // their pre-edge values here.
  always @(posedge clk_i) begin : result_monitor
    alu_rsp_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{result_value_o, remainder_value_o, write_result_o, branch_taken_o,
              flag_n_o, flag_z_o, flag_v_o, flag_c_o, divide_by_zero_o};
      alu_flags.check_result(got);
    end
  end

  // Watchdog: any run of cycles with no handshake on either side that
  // outlasts the limit means the block has hung.
  initial begin : hang_watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < StallLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  function automatic alu_req_t make_request(cmd_t c, size_t s, logic [31:0] src,
                                            logic [31:0] dst, logic [1:0] sel, cond_t cond);
    alu_req_t r;
    r.command  = c;
    r.size     = s;
    r.source   = src;
    r.dest     = dst;
    r.flag_sel = sel;
    r.cond     = cond;
    return r;
  endfunction

  // Operands lean towards the corners where N, Z, V and C change.
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(7))
      0:       return 32'h0000_0000;
      1:       return 32'hffff_ffff;
      2:       return 32'h8000_0000;
      3:       return 32'h7fff_ffff;
      4:       return $urandom_range(255);
      5:       return $urandom_range(65535);
      // powers of two and one below: 0x80, 0x7f, 0x10000, 0xffff, ...
      6:       return (32'd1 << $urandom_range(31)) - $urandom_range(1);
      default: return $urandom();
    endcase
  endfunction

  // Mostly arithmetic that sets flags, a good share of branch tests that
  // read them back, and now and then a flag command or a no-op.
  function automatic alu_req_t random_request();
    alu_req_t    r;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 6)
      r.command = cmd_t'($urandom_range(CmdBranch + 1, CmdUnused));
    else if (pick < 28)
      r.command = CmdBranch;
    else if (pick < 36)
      r.command = ($urandom_range(1) != 0) ? CmdSet : CmdClr;
    else
      r.command = cmd_t'($urandom_range(CmdMove, CmdMul));
    r.size     = size_t'($urandom_range(SizeSpare));
    r.source   = pick_operand();
    r.dest     = pick_operand();
    r.flag_sel = 2'($urandom_range(3));
    r.cond     = cond_t'($urandom_range(CondNever));
    return r;
  endfunction

  // Offers one request and returns at the edge that takes it. Valid stays
  // high on return so back-to-back requests need no extra assignment.
  task automatic send_request(alu_req_t r);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    command_i          <= r.command;
    size_code_i        <= r.size;
    source_value_i     <= r.source;
    dest_value_i       <= r.dest;
    flag_select_i      <= r.flag_sel;
    branch_condition_i <= r.cond;
    in_valid_i         <= 1'b1;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
    alu_flags.note_request(r);
  endtask

  // Sender goes quiet until every outstanding response is back.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (alu_flags.pending() != 0) @(posedge clk_i);
  endtask

  initial begin : stimulus
    alu_req_t    directed[$];
    int unsigned idle_plan[4][2];

    alu_flags = new();

    rst_ni             <= 1'b0;
    in_valid_i         <= 1'b0;
    command_i          <= CmdMove;
    size_code_i        <= SizeByte;
    source_value_i     <= 32'd0;
    dest_value_i       <= 32'd0;
    flag_select_i      <= 2'd0;
    branch_condition_i <= CondNe;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: each command, operand extremes, flags read back by branches.
    directed.push_back(make_request(CmdMove, SizeWord, 32'h8000_0000, 32'd0, 2'd0, CondNe));
    directed.push_back(make_request(CmdBranch, SizeWord, 32'd0, 32'd0, 2'd0, CondMi));
    // byte move of 0x100: zero in the byte, carry from bit 8
    directed.push_back(make_request(CmdMove, SizeByte, 32'h0000_0100, 32'd0, 2'd0, CondNe));
    directed.push_back(make_request(CmdBranch, SizeByte, 32'd0, 32'd0, 2'd0, CondLos));
    directed.push_back(make_request(CmdAdd, SizeByte, 32'h0000_007f, 32'h1, 2'd0, CondNe));
    directed.push_back(make_request(CmdBranch, SizeByte, 32'd0, 32'd0, 2'd0, CondVs));
    directed.push_back(make_request(CmdAdd, SizeWord, 32'hffff_ffff, 32'h1, 2'd0, CondNe));
    // word subtract that borrows: truncation leaves carry clear
    directed.push_back(make_request(CmdSub, SizeWord, 32'h1, 32'h0, 2'd0, CondNe));
    directed.push_back(make_request(CmdBranch, SizeWord, 32'd0, 32'd0, 2'd0, CondCs));
    directed.push_back(make_request(CmdSub, SizeHalf, 32'h1, 32'h0000_8000, 2'd0, CondNe));
    // compare is source minus dest and writes nothing back
    directed.push_back(make_request(CmdCmp, SizeByte, 32'h0, 32'h1, 2'd0, CondNe));
    directed.push_back(make_request(CmdCmp, SizeSpare, 32'h7fff_ffff, 32'hffff_ffff, 2'd0,
                                    CondNe));
    directed.push_back(make_request(CmdDiv, SizeSpare, 32'h3, 32'hffff_ffff, 2'd0, CondNe));
    // divide by zero: error raised, flags kept
    directed.push_back(make_request(CmdDiv, SizeWord, 32'h0, 32'h5, 2'd0, CondNe));
    directed.push_back(make_request(CmdMul, SizeWord, 32'hffff_ffff, 32'hffff_ffff, 2'd0,
                                    CondNe));
    directed.push_back(make_request(CmdMul, SizeByte, 32'h10, 32'h10, 2'd0, CondNe));
    directed.push_back(make_request(CmdSet, SizeByte, 32'd0, 32'd0, 2'(FlagC), CondNe));
    directed.push_back(make_request(CmdSet, SizeByte, 32'd0, 32'd0, 2'(FlagV), CondNe));
    directed.push_back(make_request(CmdSet, SizeByte, 32'd0, 32'd0, 2'(FlagN), CondNe));
    directed.push_back(make_request(CmdSet, SizeByte, 32'd0, 32'd0, 2'(FlagZ), CondNe));
    directed.push_back(make_request(CmdBranch, SizeByte, 32'd0, 32'd0, 2'd0, CondNever));
    directed.push_back(make_request(CmdClr, SizeByte, 32'd0, 32'd0, 2'(FlagZ), CondNe));
    directed.push_back(make_request(CmdBranch, SizeByte, 32'd0, 32'd0, 2'd0, CondAl));
    // unused command codes leave everything alone
    directed.push_back(make_request(CmdUnused, SizeSpare, 32'hffff_ffff, 32'hffff_ffff, 2'd3,
                                    CondNever));
    directed.push_back(make_request(cmd_t'(CmdBranch + 1), SizeWord, 32'h1234_5678,
                                    32'h8765_4321, 2'd1, CondAl));
    foreach (directed[i]) send_request(directed[i]);
    drain();

    // Random phases: free-running, sender idling, receiver stalling, both.
    idle_plan = '{'{0, 0}, '{53, 0}, '{0, 53}, '{22, 22}};
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = idle_plan[p][0];
      recv_stall_pct = idle_plan[p][1];
      for (int i = 0; i < PhaseRequests; i++) begin
        // long receiver hold-off while requests keep coming
        if (p == 0 && i == PhaseRequests / 2) hold_off_req = 1'b1;
        send_request(random_request());
      end
      drain();
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (alu_flags.failures == 0 && alu_flags.pending() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
